>>> hw/rtl/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types, codes and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvr_pkg;

  localparam int TABLE_NODES = 4;   // storage is always 4 x 4
  localparam int NODE_W      = 2;
  localparam int COST_W      = 16;
  localparam int IN_COST_W   = 14;
  localparam int HOP_W       = 3;
  localparam int CNT_W       = 16;
  localparam int NODES_DEF   = 4;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [COST_W-1:0] CRASH_COST = 16'd9999;
  localparam logic [COST_W-1:0] INIT_COST  = 16'd999;
  localparam logic [COST_W-1:0] SUM_MAX    = 16'hFFFF;
  localparam logic [HOP_W-1:0]  NO_HOP     = 3'd4;

  // action codes
  localparam logic [2:0] ACT_VECTOR = 3'd0;
  localparam logic [2:0] ACT_LINK   = 3'd1;
  localparam logic [2:0] ACT_REMOTE = 3'd2;
  localparam logic [2:0] ACT_CRASH  = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;
  localparam logic [2:0] ACT_PKTS   = 3'd5;

  // register indexes
  localparam logic [1:0] REG_SELF_ID  = 2'd0;
  localparam logic [1:0] REG_ACTIVE   = 2'd1;
  localparam logic [1:0] REG_NBR_MASK = 2'd2;

  typedef logic [TABLE_NODES-1:0][COST_W-1:0] cost_row_t;

  localparam cost_row_t INIT_ROW = {TABLE_NODES{INIT_COST}};

  typedef struct packed {
    logic [2:0]           action;
    logic [NODE_W-1:0]    node_id;
    logic [IN_COST_W-1:0] link_cost;
    logic [IN_COST_W-1:0] cost_0;
    logic [IN_COST_W-1:0] cost_1;
    logic [IN_COST_W-1:0] cost_2;
    logic [IN_COST_W-1:0] cost_3;
  } in_beat_t;

  typedef struct packed {
    logic [HOP_W-1:0]  next_hop;
    logic [COST_W-1:0] route_cost;
    logic [CNT_W-1:0]  packet_count;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    cost_row_t         data;
  } row_wr_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? SUM_MAX : s[COST_W-1:0];
  endfunction

endpackage

>>> hw/rtl/dvr_row_mem.sv
// ----------------------------------------------------------------------------
// dvr_row_mem
// Cost table: one row per node, two registered read ports, one write port.
// Rows never written since reset read back as all 999.
// ----------------------------------------------------------------------------
module dvr_row_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dvr_pkg::NODE_W-1:0] rd_a_addr,
  input  logic [dvr_pkg::NODE_W-1:0] rd_b_addr,
  output dvr_pkg::cost_row_t        rd_a_data,
  output dvr_pkg::cost_row_t        rd_b_data,
  input  dvr_pkg::row_wr_t          wr
);

  dvr_pkg::cost_row_t mem [dvr_pkg::TABLE_NODES];
  dvr_pkg::cost_row_t rd_a_r;
  dvr_pkg::cost_row_t rd_b_r;
  logic [dvr_pkg::TABLE_NODES-1:0] vld_r;
  logic rd_a_vld_r;
  logic rd_b_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_a_vld_r <= 1'b0;
      rd_b_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_a_vld_r <= vld_r[rd_a_addr];
      rd_b_vld_r <= vld_r[rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_vld_r ? rd_a_r : dvr_pkg::INIT_ROW;
  assign rd_b_data = rd_b_vld_r ? rd_b_r : dvr_pkg::INIT_ROW;

endmodule

>>> hw/rtl/distance_vector_route_table_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Distance-vector route table with Bellman-Ford relaxation of the own row.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_data when start is high and busy is low. Each item
//   gives exactly one result beat on out_data, flagged by out_strobe for a
//   single cycle; the receiver must take it then, there is no backpressure.
//   Configuration (self_id, active_nodes, neighbor_mask) goes through the
//   APB port at byte addresses 0, 4, 8 while the block is idle.
// Timing:
//   The accepting edge reads the own row and the addressed node's row from
//   the row memory. The next cycle relaxes the four lanes and writes the own
//   row; the result strobe follows in the cycle after that. A vector or a
//   crash notice for a node other than self also writes the sender's row,
//   which uses an extra WB state on the single memory write port. Busy is
//   high in EXEC and WB, so an item is taken only once the last is done.
// Reset:
//   Clears control state; the cost table reads 999 everywhere through
//   per-row valid bits, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top #(
  parameter int NODES = dvr_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  dvr_pkg::in_beat_t           in_data,
  // result channel
  output logic                        out_strobe,
  output dvr_pkg::out_beat_t          out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0]  paddr,
  input  logic [dvr_pkg::DATA_W-1:0]  pwdata,
  output logic [dvr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WB} state_t;

  state_t state_r, state_nxt;

  logic [1:0] self_id_r;
  logic [2:0] active_nodes_r;
  logic [3:0] neighbor_mask_r;

  dvr_pkg::in_beat_t  item_r;
  logic [dvr_pkg::NODE_W-1:0] me_r;
  dvr_pkg::cost_row_t snd_row_r, snd_row_nxt;

  logic [dvr_pkg::HOP_W-1:0] hop_r   [dvr_pkg::TABLE_NODES];
  logic [dvr_pkg::HOP_W-1:0] hop_nxt [dvr_pkg::TABLE_NODES];
  logic [dvr_pkg::CNT_W-1:0] update_count_r, update_count_nxt;

  logic               out_strobe_r, out_strobe_nxt;
  dvr_pkg::out_beat_t out_data_r, out_data_nxt;

  logic [dvr_pkg::NODE_W-1:0] rd_a_addr, rd_b_addr;
  dvr_pkg::cost_row_t own_old, snd_old;
  dvr_pkg::row_wr_t   row_wr;

  logic accept;
  logic cfg_write;
  logic [2:0] used_n;

  // EXEC datapath
  dvr_pkg::cost_row_t vec_row, snd_new, own_base, own_new, own_lc, scan_row;
  logic [dvr_pkg::COST_W-1:0] cand [dvr_pkg::TABLE_NODES];
  logic [dvr_pkg::TABLE_NODES-1:0] improve;
  logic [dvr_pkg::NODE_W-1:0] nd;
  logic self_hit;
  logic scan_found;
  logic [dvr_pkg::NODE_W-1:0] scan_tgt;
  logic snd_wr_need;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign used_n    = (active_nodes_r > 3'(NODES)) ? 3'(NODES) : active_nodes_r;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r       <= 2'd0;
      active_nodes_r  <= 3'd4;
      neighbor_mask_r <= 4'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        dvr_pkg::REG_SELF_ID:  self_id_r       <= pwdata[1:0];
        dvr_pkg::REG_ACTIVE:   active_nodes_r  <= pwdata[2:0];
        dvr_pkg::REG_NBR_MASK: neighbor_mask_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dvr_pkg::REG_SELF_ID:  prdata = {30'd0, self_id_r};
      dvr_pkg::REG_ACTIVE:   prdata = {29'd0, active_nodes_r};
      dvr_pkg::REG_NBR_MASK: prdata = {28'd0, neighbor_mask_r};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // row memory
  // --------------------------------------------------------------------------
  assign rd_a_addr = self_id_r;
  assign rd_b_addr = in_data.node_id;

  dvr_row_mem u_row_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (own_old),
    .rd_b_data (snd_old),
    .wr        (row_wr)
  );

  // --------------------------------------------------------------------------
  // relaxation lanes
  // --------------------------------------------------------------------------
  assign nd       = item_r.node_id;
  assign self_hit = (nd == me_r);

  always_comb begin
    vec_row[0] = dvr_pkg::COST_W'(item_r.cost_0);
    vec_row[1] = dvr_pkg::COST_W'(item_r.cost_1);
    vec_row[2] = dvr_pkg::COST_W'(item_r.cost_2);
    vec_row[3] = dvr_pkg::COST_W'(item_r.cost_3);

    // sender row after the store / crash fill of used lanes
    for (int i = 0; i < dvr_pkg::TABLE_NODES; i++) begin
      snd_new[i] = snd_old[i];
      if (3'(i) < used_n) begin
        if (item_r.action == dvr_pkg::ACT_VECTOR) begin
          snd_new[i] = vec_row[i];
        end else if (item_r.action == dvr_pkg::ACT_CRASH) begin
          snd_new[i] = dvr_pkg::CRASH_COST;
        end
      end
    end

    own_base = self_hit ? snd_new : own_old;

    // vector: min over each lane through the sender
    for (int i = 0; i < dvr_pkg::TABLE_NODES; i++) begin
      cand[i]    = dvr_pkg::sat_add(own_base[nd], snd_new[i]);
      improve[i] = (3'(i) < used_n) && (cand[i] < own_base[i]);
    end

    // link set, remote change base
    own_lc     = own_base;
    own_lc[nd] = dvr_pkg::COST_W'(item_r.link_cost);
    scan_row   = self_hit ? own_lc : snd_old;

    // highest-numbered node that is neither a neighbor nor self
    scan_found = 1'b0;
    scan_tgt   = '0;
    for (int k = NODES - 1; k >= 0; k--) begin
      if (!scan_found && !neighbor_mask_r[k] && (dvr_pkg::NODE_W'(k) != me_r)) begin
        scan_found = 1'b1;
        scan_tgt   = dvr_pkg::NODE_W'(k);
      end
    end

    own_new = own_base;
    case (item_r.action)
      dvr_pkg::ACT_VECTOR: begin
        for (int i = 0; i < dvr_pkg::TABLE_NODES; i++) begin
          if (improve[i]) begin
            own_new[i] = cand[i];
          end
        end
      end
      dvr_pkg::ACT_LINK: own_new = own_lc;
      dvr_pkg::ACT_REMOTE: begin
        own_new = own_lc;
        if (scan_found) begin
          own_new[scan_tgt] = dvr_pkg::sat_add(own_lc[nd], scan_row[scan_tgt]);
        end
      end
      dvr_pkg::ACT_CRASH: own_new[nd] = dvr_pkg::CRASH_COST;
      default: ;
    endcase

    snd_wr_need = ((item_r.action == dvr_pkg::ACT_VECTOR) ||
                   (item_r.action == dvr_pkg::ACT_CRASH)) && !self_hit;
  end

  // write port: own row in EXEC, sender row in WB
  always_comb begin
    row_wr.en   = 1'b0;
    row_wr.addr = me_r;
    row_wr.data = own_new;
    if (state_r == ST_EXEC) begin
      row_wr.en = (item_r.action inside {dvr_pkg::ACT_VECTOR, dvr_pkg::ACT_LINK,
                                         dvr_pkg::ACT_REMOTE, dvr_pkg::ACT_CRASH});
    end else if (state_r == ST_WB) begin
      row_wr.en   = 1'b1;
      row_wr.addr = nd;
      row_wr.data = snd_row_r;
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    hop_nxt          = hop_r;
    update_count_nxt = update_count_r;
    out_strobe_nxt   = 1'b0;
    out_data_nxt     = '0;
    snd_row_nxt      = snd_new;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = snd_wr_need ? ST_WB : ST_IDLE;
        case (item_r.action)
          dvr_pkg::ACT_VECTOR: begin
            for (int i = 0; i < dvr_pkg::TABLE_NODES; i++) begin
              if (improve[i]) begin
                hop_nxt[i] = dvr_pkg::HOP_W'(nd);
              end
            end
            update_count_nxt = update_count_r + 1'b1;
          end
          dvr_pkg::ACT_LINK: hop_nxt[nd] = dvr_pkg::HOP_W'(nd);
          dvr_pkg::ACT_REMOTE: begin
            hop_nxt[nd] = dvr_pkg::HOP_W'(nd);
            if (scan_found) begin
              hop_nxt[scan_tgt] = dvr_pkg::HOP_W'(nd);
            end
            update_count_nxt = update_count_r + 1'b1;
          end
          dvr_pkg::ACT_QUERY: begin
            out_data_nxt.next_hop   = hop_r[nd];
            out_data_nxt.route_cost = own_old[nd];
          end
          dvr_pkg::ACT_PKTS: begin
            out_data_nxt.packet_count = update_count_r;
            update_count_nxt          = '0;
          end
          default: ;
        endcase
      end
      ST_WB: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_strobe_r   <= 1'b0;
      out_data_r     <= '0;
      update_count_r <= '0;
      hop_r[0]       <= '0;
      for (int i = 1; i < dvr_pkg::TABLE_NODES; i++) begin
        hop_r[i] <= dvr_pkg::NO_HOP;
      end
    end else begin
      state_r        <= state_nxt;
      out_strobe_r   <= out_strobe_nxt;
      out_data_r     <= out_data_nxt;
      update_count_r <= update_count_nxt;
      hop_r          <= hop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      me_r   <= self_id_r;
    end
    if (state_r == ST_EXEC) begin
      snd_row_r <= snd_row_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
